### rtl/core/pfsa_pkg.sv
// shared types and constants for the page free-stack allocator
// no dependencies
package pfsa_pkg;

  localparam int unsigned PagesDefault = 1024;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned GrainW = 25;
  localparam int unsigned CountW = 11;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned StatW  = 3;

  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegGrain = 2'd1;
  localparam logic [1:0] RegCount = 2'd2;

  typedef enum logic [StatW-1:0] {
    StOk        = 3'd0,
    StNoFree    = 3'd1,
    StDoubleAlc = 3'd2,
    StRange     = 3'd3,
    StDoubleFre = 3'd4
  } status_e;

  // front-end classified request
  typedef struct packed {
    logic             is_free;
    logic             range_ok;
    logic [AddrW-1:0] offset;
  } req_t;

endpackage

### rtl/core/pfsa_ram.sv
// generic single-port-write, one-read ram with registered read
// no dependencies
module pfsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/pfsa_front.sv
// front end: takes commands, checks free addresses against the region
// depends on pfsa_pkg
module pfsa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          command_i,
  input  logic [pfsa_pkg::AddrW-1:0]    address_i,
  input  logic [pfsa_pkg::AddrW-1:0]    base_i,
  input  logic [pfsa_pkg::GrainW-1:0]   grain_i,
  input  logic [pfsa_pkg::CountW-1:0]   live_i,
  output logic                          q_valid_o,
  input  logic                          q_pop_i,
  output pfsa_pkg::req_t                q_req_o
);
  import pfsa_pkg::*;

  // region size as live*grain; 11x25 product fits one multiplier
  logic [GrainW+CountW-1:0] span;
  logic                     in_range;
  req_t                     req_in;
  req_t                     fifo_q [2];
  logic                     wr_q, rd_q;
  logic [1:0]               cnt_q;

  assign span = GrainW'(grain_i) * live_i;

  // compare offset against span without wrap
  always_comb begin
    in_range = (grain_i != '0) && (address_i >= base_i) &&
               ({4'd0, address_i - base_i} < span);
    req_in.is_free  = command_i;
    req_in.range_ok = in_range;
    req_in.offset   = address_i - base_i;
  end

  assign full_o    = cnt_q == 2'd2;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_req_o   = fifo_q[rd_q];

  // two-entry queue to the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (q_pop_i && q_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(q_pop_i && q_valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) fifo_q[wr_q] <= req_in;
  end

endmodule

### rtl/core/pfsa_back.sv
// back end: serial divider, multiplier, free stack, used bitmap, result register
// depends on pfsa_pkg, pfsa_ram
module pfsa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [pfsa_pkg::AddrW-1:0]    base_i,
  input  logic [pfsa_pkg::GrainW-1:0]   grain_i,
  input  logic [pfsa_pkg::CountW-1:0]   live_i,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  pfsa_pkg::req_t                q_req_i,
  output logic                          empty_o,
  input  logic                          pop,
  output logic [pfsa_pkg::AddrW-1:0]    page_address_o,
  output logic [pfsa_pkg::IdxW-1:0]     page_index_o,
  output logic [2:0]                    status_o,
  output logic [pfsa_pkg::CountW-1:0]   free_pages_o
);
  import pfsa_pkg::*;

  localparam int unsigned Pages = PagesDefault;
  localparam int unsigned PW = $clog2(Pages);
  localparam int unsigned DW = $clog2(Pages + 1);

  typedef enum logic [2:0] {
    SIdle, SDiv, SLook, SRead, SMul, SDone
  } bstate_e;

  bstate_e state_q, state_d;

  logic [DW-1:0]    depth_q, depth_d;
  // lowest depth since clear: stack slots and bitmap entries below it
  // were never written, so a slot holds its own index and a page is free
  logic [DW-1:0]    low_q;
  logic             is_free_q;
  logic [AddrW-1:0] quo_q;
  logic [GrainW-1:0] rem_q;
  logic [5:0]       cnt_q;
  logic [PW-1:0]    idx_q;
  logic [AddrW-1:0] prod_q;

  logic             ram_we;
  logic [PW-1:0]    ram_wa, ram_ra;
  logic [PW-1:0]    ram_rd;
  logic [PW-1:0]    top_idx;

  logic             used_we, used_wd, used_rd, idx_used;
  logic [PW-1:0]    used_ra;

  logic             res_v_q;
  logic [AddrW-1:0] r_addr_q;
  logic [IdxW-1:0]  r_idx_q;
  logic [2:0]       r_st_q;
  logic [CountW-1:0] r_free_q;

  logic fin;
  logic [2:0] st_fin;
  logic [PW-1:0] idx_fin;

  pfsa_ram #(.Width(PW), .Depth(Pages)) u_stack (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(idx_fin),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // allocation bitmap, one bit per page
  pfsa_ram #(.Width(1), .Depth(Pages)) u_used (
    .clk_i, .we_i(used_we), .waddr_i(idx_fin), .wdata_i(used_wd),
    .raddr_i(used_ra), .rdata_o(used_rd)
  );

  assign ram_ra  = PW'(depth_q - DW'(1));
  assign top_idx = (depth_q <= low_q) ? PW'(depth_q - DW'(1)) : ram_rd;
  assign used_ra = (state_q == SRead) ? top_idx : (is_free_q ? PW'(quo_q) : idx_q);

  // restoring divider step
  logic [GrainW:0] trial;
  assign trial = {rem_q, quo_q[AddrW-1]};

  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    ram_wa   = PW'(depth_q);
    used_we  = 1'b0;
    used_wd  = 1'b0;
    fin      = 1'b0;
    st_fin   = StOk;
    idx_fin  = '0;
    idx_used = 1'b0;
    unique case (state_q)
      SIdle: if (q_valid_i && !res_v_q) begin
        q_pop_o = 1'b1;
        state_d = q_req_i.is_free ? (q_req_i.range_ok ? SDiv : SDone) : SRead;
      end
      SDiv: if (cnt_q == 6'd0) state_d = SLook;
      SLook: state_d = SDone;
      SRead: state_d = SMul;
      SMul: state_d = SDone;
      SDone: begin
        fin = 1'b1;
        state_d = SIdle;
        if (is_free_q) begin
          if (cnt_q == 6'd63 || quo_q >= AddrW'(Pages)) st_fin = StRange;
          else begin
            idx_fin  = PW'(quo_q);
            idx_used = used_rd && (DW'(idx_fin) >= low_q);
            if (!idx_used) st_fin = StDoubleFre;
            else begin
              used_we = 1'b1;
              used_wd = 1'b0;
              if (depth_q < DW'(Pages)) begin
                ram_we  = 1'b1;
                depth_d = depth_q + DW'(1);
              end
            end
          end
        end else if (depth_q == '0) st_fin = StNoFree;
        else begin
          idx_fin  = idx_q;
          idx_used = used_rd && (DW'(idx_fin) >= low_q);
          if (idx_used) st_fin = StDoubleAlc;
          else begin
            depth_d = depth_q - DW'(1);
            used_we = 1'b1;
            used_wd = 1'b1;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      depth_q <= DW'(Pages);
      low_q   <= DW'(Pages);
      res_v_q <= 1'b0;
    end else begin
      if (clear_i) begin
        depth_q <= (live_i > CountW'(Pages)) ? DW'(Pages) : DW'(live_i);
        low_q   <= (live_i > CountW'(Pages)) ? DW'(Pages) : DW'(live_i);
        state_q <= SIdle;
      end else begin
        state_q <= state_d;
        depth_q <= depth_d;
        if (depth_d < low_q) low_q <= depth_d;
      end
      if (fin) res_v_q <= 1'b1;
      else if (pop && res_v_q) res_v_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && q_pop_o) begin
      is_free_q <= q_req_i.is_free;
      quo_q     <= q_req_i.offset;
      rem_q     <= '0;
      cnt_q     <= q_req_i.range_ok ? 6'(AddrW - 1) : 6'd63;
    end
    if (state_q == SDiv) begin
      if (trial >= {1'b0, grain_i}) begin
        rem_q <= GrainW'(trial - {1'b0, grain_i});
        quo_q <= {quo_q[AddrW-2:0], 1'b1};
      end else begin
        rem_q <= GrainW'(trial);
        quo_q <= {quo_q[AddrW-2:0], 1'b0};
      end
      if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
    end
    if (state_q == SRead) idx_q <= top_idx;
    if (state_q == SMul) prod_q <= AddrW'(idx_q) * AddrW'(grain_i);
    if (fin) begin
      r_st_q   <= st_fin;
      r_idx_q  <= IdxW'(idx_fin);
      r_free_q <= CountW'(depth_d);
      r_addr_q <= (!is_free_q && st_fin == StOk) ? base_i + prod_q : '0;
    end
  end

  assign empty_o        = !res_v_q;
  assign page_address_o = r_addr_q;
  assign page_index_o   = r_idx_q;
  assign status_o       = r_st_q;
  assign free_pages_o   = r_free_q;

endmodule

### rtl/core/page_free_stack_allocator_core.sv
// Page allocator: one result per command. An allocate goes through a stack
// read, a bitmap read and one multiply after acceptance; a free inside the
// region runs a one-bit-per-cycle restoring divider over 32 steps, and a
// free outside it goes straight to the result. The back end starts a command
// only after the previous result has been popped, so result stalls hold off
// the next command. A two-entry queue buffers commands; any write to the base,
// grain or count register resets the stack and bitmap with no sweep.
// depends on pfsa_pkg, pfsa_front, pfsa_back, pfsa_ram
module page_free_stack_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        command_i,
  input  logic [pfsa_pkg::AddrW-1:0]  address_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [pfsa_pkg::AddrW-1:0]  page_address_o,
  output logic [pfsa_pkg::IdxW-1:0]   page_index_o,
  output logic [pfsa_pkg::StatW-1:0]  status_o,
  output logic [pfsa_pkg::CountW-1:0] free_pages_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import pfsa_pkg::*;

  localparam int unsigned Pages = PagesDefault;

  logic [AddrW-1:0]  base_q;
  logic [GrainW-1:0] grain_q;
  logic [CountW-1:0] count_q, live;
  logic [CountW-1:0] cfg_count, clear_live;
  logic              cfg_wr;
  logic              clear;
  logic              q_valid, q_pop;
  req_t              q_req;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;
  assign clear  = cfg_wr && (cfg_index_i inside {RegBase, RegGrain, RegCount});
  assign live   = (count_q > CountW'(Pages)) ? CountW'(Pages) : count_q;

  // pool size the clear loads, taking a page count write into account
  assign cfg_count  = cfg_data_i[CountW-1:0];
  assign clear_live = (cfg_index_i == RegCount) ?
                      ((cfg_count > CountW'(Pages)) ? CountW'(Pages) : cfg_count) : live;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 32'd65536;
      grain_q <= 25'd65536;
      count_q <= 11'd1024;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        RegBase:  base_q  <= cfg_data_i;
        RegGrain: grain_q <= cfg_data_i[GrainW-1:0];
        RegCount: count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  pfsa_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .command_i, .address_i,
    .base_i(base_q), .grain_i(grain_q), .live_i(live),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  pfsa_back u_back (
    .clk_i, .rst_ni, .clear_i(clear), .base_i(base_q), .grain_i(grain_q),
    .live_i(clear_live), .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .empty_o(empty), .pop, .page_address_o, .page_index_o, .status_o,
    .free_pages_o
  );

  // result codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o <= StDoubleFre) else $error("bad status");
  // free count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> free_pages_o <= CountW'(Pages)) else $error("free count overflow");
  // errored results return no address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != StOk) |-> page_address_o == '0) else $error("addr on error");

endmodule
